// ===== design/rsa_me_pkg.sv =====
package rsa_me_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgModulus  = 2'd0;
  localparam logic [1:0] CfgEncExp   = 2'd1;
  localparam logic [1:0] CfgDecExp   = 2'd2;
  localparam logic [1:0] CfgOffset   = 2'd3;

  // register values after reset
  localparam int unsigned ModulusRst = 1003;
  localparam int unsigned EncExpRst  = 3;
  localparam int unsigned DecExpRst  = 619;
  localparam logic [7:0]  OffsetRst  = 8'd96;

  // input action codes
  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  // status of the serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== design/rsa_me_mulmod.sv =====
module rsa_me_mulmod #(
  parameter int unsigned WORD_BITS = 16,
  parameter int unsigned A_BITS    = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [A_BITS-1:0]      a_i,
  input  logic [WORD_BITS-1:0]   b_i,
  input  logic [WORD_BITS-1:0]   n_i,
  output logic [WORD_BITS-1:0]   result_o,
  output rsa_me_pkg::mul_stat_t  stat_o
);

  localparam int unsigned CntBits = $clog2(A_BITS + 1);

  logic [A_BITS-1:0]    a_q;
  logic [WORD_BITS-1:0] b_q;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q, done_q;

  logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;

  // one bit of a per cycle, msb first: acc = 2*acc + bit*b, kept below n
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_i}) ? dbl - {1'b0, n_i} : dbl;
    sum     = {1'b0, dbl_red[WORD_BITS-1:0]} + (a_q[A_BITS-1] ? {1'b0, b_q} : '0);
    sum_red = (sum >= {1'b0, n_i}) ? sum - {1'b0, n_i} : sum;
    acc_d   = sum_red[WORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(A_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[A_BITS-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign result_o    = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== design/rsa_modular_exponentiation.sv =====
// channel   direction  fields                  handshake
// in        input      action_i, value_i       in_valid_i / in_ready_o
// out       output     residue_o, out_byte_o   out_valid_o / out_ready_i
// cfg       input      cfg_idx_i, cfg_data_i   cfg_we_i, no wait
//
// one transaction at a time; every multiply and the input reduction run through a
// bit-serial modular multiplier, one operand bit per cycle; a transaction runs the
// reduction and up to 2 * WORD_BITS - 1 multiplies; modulus below two returns at once
// reset is asynchronous, active low, and loads the default key registers
// a result waits in the output register; the next transaction is taken meanwhile
module rsa_modular_exponentiation #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     action_i,
  input  logic [WORD_BITS-1:0]                     value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [WORD_BITS-1:0]                     residue_o,
  output logic [7:0]                               out_byte_o,
  input  logic                                     cfg_we_i,
  input  logic [1:0]                               cfg_idx_i,
  input  logic [((WORD_BITS > 8) ? WORD_BITS : 8)-1:0] cfg_data_i
);

  localparam int unsigned ABits = (WORD_BITS > 8) ? WORD_BITS : 8;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRed  = 3'd1;
  localparam logic [2:0] SFix  = 3'd2;
  localparam logic [2:0] SBit  = 3'd3;
  localparam logic [2:0] SMul  = 3'd4;
  localparam logic [2:0] SSqr  = 3'd5;
  localparam logic [2:0] SDone = 3'd6;

  logic [WORD_BITS-1:0] modulus_q, enc_exp_q, dec_exp_q;
  logic [7:0]           offset_q;

  logic [2:0]           state_q;
  logic                 start_q;
  logic [ABits-1:0]     op_a_q;
  logic [WORD_BITS-1:0] op_b_q;
  logic [WORD_BITS-1:0] base_q, acc_q, exp_q;
  logic                 neg_q;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] residue_q;
  logic [7:0]           out_byte_q;

  logic [WORD_BITS-1:0]  mul_res;
  rsa_me_pkg::mul_stat_t mul_stat;

  logic                 accept;
  logic [ABits-1:0]     val_ext, off_ext, diff;
  logic                 val_ge;
  logic                 out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // distance of value and offset (decrypt: value); sign is handled after reduction
  always_comb begin
    val_ext = ABits'(value_i);
    off_ext = ABits'(offset_q);
    val_ge  = val_ext >= off_ext;
    if (action_i == rsa_me_pkg::ActDecrypt) begin
      diff = val_ext;
    end else if (val_ge) begin
      diff = val_ext - off_ext;
    end else begin
      diff = off_ext - val_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= WORD_BITS'(rsa_me_pkg::ModulusRst);
      enc_exp_q <= WORD_BITS'(rsa_me_pkg::EncExpRst);
      dec_exp_q <= WORD_BITS'(rsa_me_pkg::DecExpRst);
      offset_q  <= rsa_me_pkg::OffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsa_me_pkg::CfgModulus: modulus_q <= cfg_data_i[WORD_BITS-1:0];
        rsa_me_pkg::CfgEncExp:  enc_exp_q <= cfg_data_i[WORD_BITS-1:0];
        rsa_me_pkg::CfgDecExp:  dec_exp_q <= cfg_data_i[WORD_BITS-1:0];
        rsa_me_pkg::CfgOffset:  offset_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            if (modulus_q < WORD_BITS'(2)) begin
              state_q <= SDone;
            end else begin
              start_q <= 1'b1;
              state_q <= SRed;
            end
          end
        end
        SRed: begin
          if (mul_stat.done) begin
            state_q <= SFix;
          end
        end
        SFix: state_q <= SBit;
        SBit: begin
          if (exp_q == '0) begin
            state_q <= SDone;
          end else begin
            start_q <= 1'b1;
            state_q <= exp_q[0] ? SMul : SSqr;
          end
        end
        SMul: begin
          if (mul_stat.done) begin
            if (exp_q[WORD_BITS-1:1] == '0) begin
              state_q <= SBit;
            end else begin
              start_q <= 1'b1;
              state_q <= SSqr;
            end
          end
        end
        SSqr: begin
          if (mul_stat.done) begin
            state_q <= SBit;
          end
        end
        SDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // operands and working values
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (accept) begin
          op_a_q <= diff;
          op_b_q <= WORD_BITS'(1);
          acc_q  <= (modulus_q < WORD_BITS'(2)) ? '0 : WORD_BITS'(1);
          neg_q  <= (action_i == rsa_me_pkg::ActEncrypt) && !val_ge;
          exp_q  <= (action_i == rsa_me_pkg::ActDecrypt) ? dec_exp_q : enc_exp_q;
        end
      end
      SRed: begin
        if (mul_stat.done) begin
          base_q <= mul_res;
        end
      end
      SFix: begin
        // negative difference: true modulo
        if (neg_q && base_q != '0) begin
          base_q <= modulus_q - base_q;
        end
      end
      SBit: begin
        if (exp_q[0]) begin
          op_a_q <= ABits'(acc_q);
          op_b_q <= base_q;
        end else begin
          op_a_q <= ABits'(base_q);
          op_b_q <= base_q;
        end
      end
      SMul: begin
        if (mul_stat.done) begin
          acc_q  <= mul_res;
          op_a_q <= ABits'(base_q);
          op_b_q <= base_q;
          if (exp_q[WORD_BITS-1:1] == '0) begin
            exp_q <= '0;
          end
        end
      end
      SSqr: begin
        if (mul_stat.done) begin
          base_q <= mul_res;
          exp_q  <= exp_q >> 1;
        end
      end
      SDone: begin
        if (out_free) begin
          residue_q  <= acc_q;
          out_byte_q <= 8'(acc_q) + offset_q;
        end
      end
      default: ;
    endcase
  end

  rsa_me_mulmod #(
    .WORD_BITS (WORD_BITS),
    .A_BITS    (ABits)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .a_i      (op_a_q),
    .b_i      (op_b_q),
    .n_i      (modulus_q),
    .result_o (mul_res),
    .stat_o   (mul_stat)
  );

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign residue_o   = residue_q;
  assign out_byte_o  = out_byte_q;

  // multiplier finishes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == SRed || state_q == SMul || state_q == SSqr))
    else $error("multiplier done outside a wait state");

  // no new multiply is launched while one is running
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> !mul_stat.busy)
    else $error("multiply started while busy");

  // an accepted transaction leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != SIdle)
    else $error("accepted transaction left sequencer idle");

  // a squaring consumes one exponent bit
  a_exp_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSqr && mul_stat.done) |=> exp_q == ($past(exp_q) >> 1))
    else $error("exponent not shifted after squaring");

  // result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone && out_valid_q && !out_ready_i) |=> state_q == SDone)
    else $error("result overwrote a pending transaction");

endmodule
